FILE: sv/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold at every edge at which the antecedent holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// The condition must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/rgbo_pkg.sv
// Types and constants shared by the alpha-over compositing pipeline.
`default_nettype none
package rgbo_pkg;

    localparam int CH_W      = 8;
    localparam int DEN_W     = 16;
    localparam int NUM_W     = 24;
    localparam int QUO_W     = 8;
    localparam int DIV_STAGES = QUO_W;
    localparam int MUL_W     = 33;
    localparam int RECIP_LSB = 23;

    localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
    localparam logic [NUM_W-1:0] NUM_SCALE = 24'd65025;
    // ceil(2^23 / 255); exact floor division by 255 for every 16-bit value.
    localparam logic [16:0]      RECIP_255 = 17'd32897;

    typedef struct packed {
        logic [CH_W-1:0] bg_ch0;
        logic [CH_W-1:0] bg_ch1;
        logic [CH_W-1:0] bg_ch2;
        logic [CH_W-1:0] bg_alpha;
        logic [CH_W-1:0] fg_ch0;
        logic [CH_W-1:0] fg_ch1;
        logic [CH_W-1:0] fg_ch2;
        logic [CH_W-1:0] fg_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] out_ch0;
        logic [CH_W-1:0] out_ch1;
        logic [CH_W-1:0] out_ch2;
        logic [CH_W-1:0] out_alpha;
    } t_pix_out;

    // One item in flight through the divider. The divisor shifts away as the
    // quotient bits settle, so its original value travels alongside as den.
    typedef struct packed {
        t_pix_in          pix;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] dsh;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_item;

endpackage
`default_nettype wire

FILE: sv/rgbo_prep.sv
// Front stages: alpha products, output alpha numerator and divider operands.
`default_nettype none
module rgbo_prep import rgbo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pix_in   i_pix,
    output logic      o_up_en,
    input  logic      i_down_en,
    output logic      o_valid,
    output t_div_item o_item
);

    logic             r_va;
    logic             r_vb;
    logic             en_a;
    logic             en_b;
    t_pix_in          r_pix_a;
    t_pix_in          r_pix_b;
    logic [DEN_W-1:0] r_pa;
    logic [DEN_W-1:0] r_pb;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_num_a;
    logic [NUM_W-1:0] r_num_b;
    logic [DEN_W-1:0] n_pa;
    logic [DEN_W-1:0] n_pb;
    logic [NUM_W-1:0] n_num;
    logic [DEN_W:0]   w_sum;
    logic [DEN_W-1:0] n_den;

    assign en_b    = !r_vb || i_down_en;
    assign en_a    = !r_va || en_b;
    assign o_up_en = en_a;

    assign n_pa  = {8'd0, i_pix.bg_alpha} * {8'd0, CH_MAX - i_pix.fg_alpha};
    assign n_pb  = {8'd0, i_pix.fg_alpha} * {8'd0, CH_MAX};
    assign n_num = {16'd0, i_pix.fg_alpha} * NUM_SCALE;

    // The sum never exceeds 65025, so the carry bit is always clear.
    assign w_sum = {1'b0, r_pa} + {1'b0, r_pb};
    assign n_den = w_sum[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_pix_a <= i_pix;
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_num_a <= n_num;
        end
        if (en_b) begin
            r_pix_b <= r_pix_a;
            r_den   <= n_den;
            r_num_b <= r_num_a;
        end
    end

    assign o_valid    = r_vb;
    assign o_item.pix = r_pix_b;
    assign o_item.rem = r_num_b;
    assign o_item.dsh = {1'b0, r_den, 7'd0};
    assign o_item.den = r_den;
    assign o_item.quo = '0;

endmodule
`default_nettype wire

FILE: sv/rgbo_div_stage.sv
// One restoring division step that settles one quotient bit.
`default_nettype none
module rgbo_div_stage import rgbo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_up_en,
    input  logic      i_down_en,
    output logic      o_valid,
    output t_div_item o_item
);

    logic      r_valid;
    logic      en;
    logic      w_ge;
    t_div_item r_item;
    t_div_item n_item;

    assign en      = !r_valid || i_down_en;
    assign o_up_en = en;

    assign w_ge = i_item.rem >= i_item.dsh;

    always_comb begin
        n_item     = i_item;
        n_item.rem = w_ge ? (i_item.rem - i_item.dsh) : i_item.rem;
        n_item.dsh = {1'b0, i_item.dsh[NUM_W-1:1]};
        n_item.quo = {i_item.quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: sv/rgbo_blend.sv
// Back stages: channel blend, divide by 255 and the output register.
`default_nettype none
module rgbo_blend import rgbo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_up_en,
    input  logic      i_out_stall,
    output logic      o_valid,
    output t_pix_out  o_pix
);

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic                  r_v4;
    logic                  en1;
    logic                  en2;
    logic                  en3;
    logic                  en4;
    logic [CH_W-1:0]       w_c2;
    logic [DEN_W-1:0]      w_den;
    logic [2:0][CH_W-1:0]  w_fg;
    logic [2:0][CH_W-1:0]  w_bg;
    logic [2:0][DEN_W-1:0] n_pf;
    logic [2:0][DEN_W-1:0] n_pb;
    logic [MUL_W-1:0]      n_am;
    logic [2:0][DEN_W:0]   w_sum;
    logic [2:0][DEN_W-1:0] n_s;
    logic [2:0][MUL_W-1:0] n_m;
    logic [2:0][CH_W-1:0]  w_q;
    t_pix_out              n_pix;

    t_pix_in               r_pix1;
    t_pix_in               r_pix2;
    t_pix_in               r_pix3;
    logic [2:0][DEN_W-1:0] r_pf;
    logic [2:0][DEN_W-1:0] r_pb;
    logic [MUL_W-1:0]      r_am;
    logic [2:0][DEN_W-1:0] r_s;
    logic [CH_W-1:0]       r_alpha2;
    logic [CH_W-1:0]       r_alpha3;
    logic [2:0][MUL_W-1:0] r_m;
    t_pix_out              r_pix_out;

    assign en4     = !r_v4 || !i_out_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_up_en = en1;

    assign w_c2  = CH_MAX - i_item.quo;
    assign w_den = i_item.den;
    assign w_fg  = {i_item.pix.fg_ch2, i_item.pix.fg_ch1, i_item.pix.fg_ch0};
    assign w_bg  = {i_item.pix.bg_ch2, i_item.pix.bg_ch1, i_item.pix.bg_ch0};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pf[k]  = {8'd0, w_fg[k]} * {8'd0, i_item.quo};
            n_pb[k]  = {8'd0, w_bg[k]} * {8'd0, w_c2};
            // Weights sum to 255, so the blended value stays within 65025.
            w_sum[k] = {1'b0, r_pf[k]} + {1'b0, r_pb[k]};
            n_s[k]   = w_sum[k][DEN_W-1:0];
            n_m[k]   = {17'd0, r_s[k]} * {16'd0, RECIP_255};
            w_q[k]   = r_m[k][RECIP_LSB+CH_W-1:RECIP_LSB];
        end
    end

    assign n_am = {17'd0, w_den} * {16'd0, RECIP_255};

    // A transparent foreground hands the background through untouched.
    always_comb begin
        if (r_pix3.fg_alpha == '0) begin
            n_pix.out_ch0   = r_pix3.bg_ch0;
            n_pix.out_ch1   = r_pix3.bg_ch1;
            n_pix.out_ch2   = r_pix3.bg_ch2;
            n_pix.out_alpha = r_pix3.bg_alpha;
        end else begin
            n_pix.out_ch0   = w_q[0];
            n_pix.out_ch1   = w_q[1];
            n_pix.out_ch2   = w_q[2];
            n_pix.out_alpha = r_alpha3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pix1 <= i_item.pix;
            r_pf   <= n_pf;
            r_pb   <= n_pb;
            r_am   <= n_am;
        end
        if (en2) begin
            r_pix2   <= r_pix1;
            r_s      <= n_s;
            r_alpha2 <= r_am[RECIP_LSB+CH_W-1:RECIP_LSB];
        end
        if (en3) begin
            r_pix3   <= r_pix2;
            r_m      <= n_m;
            r_alpha3 <= r_alpha2;
        end
        if (en4) begin
            r_pix_out <= n_pix;
        end
    end

    assign o_valid = r_v4;
    assign o_pix   = r_pix_out;

endmodule
`default_nettype wire

FILE: sv/rgba_alpha_over_composite.sv
// Top level of the straight-alpha "over" compositing pipeline.
//
//   Channel   Direction   Handshake                  Payload
//   in        into        i_in_valid / o_in_stall    i_in_data  (t_pix_in)
//   out       out of      o_out_valid / i_out_stall  o_out_data (t_pix_out)
//
// One item can enter in every clock cycle while the input is not stalled; an item
// passes 14 register stages, the last of which is the output register.
// Most of the depth is the restoring divider that forms the foreground weight,
// one quotient bit a stage.
// Reset clears only the valid bits of the stages; there is no clearing pass.
// A stall on the output holds the last stage; empty stages upstream keep
// filling, so the input stalls only when every stage holds an item.
`default_nettype none
`include "assert_macros.svh"
module rgba_alpha_over_composite import rgbo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_pix_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pix_out o_out_data
);

    // Index 0 is the front end's output; index k+1 is divider stage k's output.
    // w_en[k] tells the producer of w_item[k] that it may advance.
    t_div_item             w_item [0:DIV_STAGES];
    logic [DIV_STAGES:0]   w_v;
    logic [DIV_STAGES:0]   w_en;
    logic                  w_front_en;

    // The front end forms bg_alpha*(255-fg_alpha) + fg_alpha*255, which is the
    // output alpha times 255 and the divisor, and fg_alpha*65025, the dividend.
    rgbo_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_pix     (i_in_data),
        .o_up_en   (w_front_en),
        .i_down_en (w_en[0]),
        .o_valid   (w_v[0]),
        .o_item    (w_item[0])
    );

    // The quotient never exceeds 255 when the foreground alpha is nonzero, so
    // eight steps give the whole weight. A zero divisor only arises with a
    // transparent foreground, whose result ignores the quotient.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        rgbo_div_stage u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_v[k]),
            .i_item    (w_item[k]),
            .o_up_en   (w_en[k]),
            .i_down_en (w_en[k+1]),
            .o_valid   (w_v[k+1]),
            .o_item    (w_item[k+1])
        );
    end

    // The back end weighs each channel, divides by 255 through a reciprocal
    // multiply and picks the background pixel for a transparent foreground.
    rgbo_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[DIV_STAGES]),
        .i_item      (w_item[DIV_STAGES]),
        .o_up_en     (w_en[DIV_STAGES]),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_pix       (o_out_data)
    );

    assign o_in_stall = !w_front_en;

    // A free or unstalled output stage lets the whole chain advance, so the input is open.
    `ASSERT_NEVER(a_stall_needs_blocked_out, i_clk, i_rst_n,
                  o_in_stall && (!o_out_valid || !i_out_stall))
    // The input stalls only when the front end's output, every divider stage and the output stage are occupied.
    `ASSERT_IMPL(a_stall_means_full, i_clk, i_rst_n,
                 o_in_stall, (&w_v) && o_out_valid)

endmodule
`default_nettype wire
